/* rtl/pbfs_pkg.sv */
package pbfs_pkg;

    localparam int WORD_BITS   = 64;
    localparam int DEPTH_WORDS = 1024;

    // Bit positions inside a word and word addresses inside the store.
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = $clog2(DEPTH_WORDS);

    // Field widths fixed by the item format.
    localparam int WIDTH_W = 7;
    localparam int CNT_W   = 17;
    // Word address derived from a bit position, one bit wider than the store
    // so that positions at or past the end stay distinct.
    localparam int WADDR_W = CNT_W - OFF_W;

    localparam int CAP_BITS = DEPTH_WORDS * WORD_BITS;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 88;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_SHIFT,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE
    } pbfs_state_t;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

/* rtl/packed_bit_field_store.sv */
// A packed bit vector of up to DEPTH_WORDS x 64 bits in a single-port word
// memory. An append item adds a 1 to 64 bit field at the current end; a read
// item returns a right-aligned field of 1 to 64 bits starting at any index up
// to the bit count, with bits past the end reading as zero. Every result
// carries the bit count after the item and an error flag (bad width, read
// index past the count, or append beyond capacity; rejected items change
// nothing). Both kinds of item go through the memory twice, once for each
// word a field may touch, and through one shared 128-bit shifter, so an
// input is taken only in the idle state. A read steps through read-low,
// read-high and shift, an append also write-low and, if the field straddles
// two words, write-high; a rejected item goes straight to done; results wait
// there on m_tready. Words beyond the filled length are tracked by the bit
// count itself: no clearing pass after reset, and the block is ready at once.
module packed_bit_field_store
    import pbfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // field_width [6:0], field_value [70:7], bit_index [87:71]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op [0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data [63:0], bit_count [80:64], zero [87:81]
    output logic [M_TDATA_W-1:0] m_tdata,
    // error [0]
    output logic [0:0]           m_tuser
);

    pbfs_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] mem [DEPTH_WORDS];
    logic [WORD_BITS-1:0] ram_q_reg;

    logic                   op_reg;
    logic [WIDTH_W-1:0]     k_reg;
    logic [WORD_BITS-1:0]   val_reg;
    logic                   err_reg;
    logic [WADDR_W-1:0]     addr_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [WORD_BITS-1:0]   lo_reg;
    logic [2*WORD_BITS-1:0] sh_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Input fields.
    logic               in_op;
    logic [WIDTH_W-1:0] in_k;
    logic [WORD_BITS-1:0] in_v;
    logic [CNT_W-1:0]   in_idx;
    logic [CNT_W:0]     in_sum;
    logic               in_err;
    logic [CNT_W-1:0]   in_base;

    assign in_op  = s_tuser[0];
    assign in_k   = s_tdata[WIDTH_W-1:0];
    assign in_v   = s_tdata[WIDTH_W+WORD_BITS-1:WIDTH_W];
    assign in_idx = s_tdata[WIDTH_W+WORD_BITS+CNT_W-1:WIDTH_W+WORD_BITS];
    assign in_sum = {1'b0, count_reg} + (CNT_W+1)'(in_k);

    always_comb begin
        if (in_k == '0 || in_k > WIDTH_W'(WORD_BITS)) begin
            in_err = 1'b1;
        end else if (in_op == OP_APPEND) begin
            in_err = 32'(in_sum) > 32'(CAP_BITS);
        end else begin
            in_err = in_idx > count_reg;
        end
    end

    assign in_base = (in_op == OP_READ) ? in_idx : count_reg;

    // Words below this address hold appended bits; all others read as zero.
    // Within a filled word every bit above the count is zero.
    logic [WADDR_W-1:0] fill_words;
    logic [CNT_W:0]     fill_sum;
    assign fill_sum   = {1'b0, count_reg} + (CNT_W+1)'(WORD_BITS - 1);
    assign fill_words = fill_sum[CNT_W-1:OFF_W];

    logic [WADDR_W-1:0] addr_p1;
    assign addr_p1 = addr_reg + WADDR_W'(1);

    logic [WORD_BITS-1:0] k_mask;
    logic [WORD_BITS-1:0] off_mask;
    logic [WORD_BITS-1:0] val_m;
    logic [WORD_BITS-1:0] hi_word;
    logic                 needs_hi;

    assign k_mask   = {WORD_BITS{1'b1}} >> (WIDTH_W'(WORD_BITS) - k_reg);
    assign off_mask = ~({WORD_BITS{1'b1}} << off_reg);
    assign val_m    = val_reg & k_mask;
    assign hi_word  = (addr_p1 < fill_words) ? ram_q_reg : '0;
    assign needs_hi = ({2'b00, off_reg} + {1'b0, k_reg}) > (WIDTH_W+1)'(WORD_BITS);

    // The shared shifter: reads align two words down by the offset, appends
    // place the value up by the offset into a two-word window.
    logic [2*WORD_BITS-1:0] sh_in;
    logic [WIDTH_W-1:0]     sh_amt;
    always_comb begin
        if (op_reg == OP_READ) begin
            sh_in  = {hi_word, lo_reg};
            sh_amt = {1'b0, off_reg};
        end else begin
            sh_in  = {val_m, {WORD_BITS{1'b0}}};
            sh_amt = WIDTH_W'(WORD_BITS) - {1'b0, off_reg};
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_err ? ST_DONE : ST_RD_LO;
                end
            end
            ST_RD_LO: state_next = ST_RD_HI;
            ST_RD_HI: state_next = ST_SHIFT;
            ST_SHIFT: state_next = (op_reg == OP_READ) ? ST_DONE : ST_WR_LO;
            ST_WR_LO: state_next = needs_hi ? ST_WR_HI : ST_DONE;
            ST_WR_HI: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 idle;
    logic                 load_out;

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = addr_reg[ADDR_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = addr_reg[ADDR_W-1:0];
        wr_data  = (lo_reg & off_mask) | sh_reg[WORD_BITS-1:0];
        idle     = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  idle = 1'b1;
            ST_RD_LO: rd_en = 1'b1;
            ST_RD_HI: begin
                rd_en   = 1'b1;
                rd_addr = addr_p1[ADDR_W-1:0];
            end
            ST_SHIFT: ;
            ST_WR_LO: wr_en = 1'b1;
            ST_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = addr_p1[ADDR_W-1:0];
                wr_data = sh_reg[2*WORD_BITS-1:WORD_BITS];
            end
            ST_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            ram_q_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    logic [WORD_BITS-1:0] res_data;
    assign res_data = (op_reg == OP_READ && !err_reg) ? (sh_reg[WORD_BITS-1:0] & k_mask) : '0;

    always_ff @(posedge aclk) begin
        if (idle && s_tvalid) begin
            op_reg   <= in_op;
            k_reg    <= in_k;
            val_reg  <= in_v;
            err_reg  <= in_err;
            addr_reg <= in_base[CNT_W-1:OFF_W];
            off_reg  <= in_base[OFF_W-1:0];
        end
        if (state_reg == ST_RD_HI) begin
            lo_reg <= (addr_reg < fill_words) ? ram_q_reg : '0;
        end
        if (state_reg == ST_SHIFT) begin
            sh_reg <= sh_in >> sh_amt;
        end
        if (load_out) begin
            m_tdata_reg <= {(M_TDATA_W-CNT_W-WORD_BITS)'(0), count_reg, res_data};
            m_tuser_reg <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_WR_LO) begin
                count_reg <= count_reg + CNT_W'(k_reg);
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb
    import pbfs_pkg::*;
();

    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_LIMIT = 5000;
    localparam int     PRINT_LIMIT = 40;
    localparam longint TIMEOUT_NS  = 64'd8_000_000;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 error;
        logic [CNT_W-1:0]     bit_count;
    } field_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    // Predictor copy of the packed vector.
    logic [WORD_BITS-1:0] model_words [DEPTH_WORDS];
    int unsigned          model_count;

    field_result_t field_expected[$];
    int            items_sent;
    int            results_checked;
    int            mismatch_count;
    bit            no_idle;
    int            hold_requests;
    int            hold_served;

    packed_bit_field_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic field_result_t predict_field_store(
        input logic                 op,
        input logic [WIDTH_W-1:0]   fw,
        input logic [WORD_BITS-1:0] fv,
        input logic [CNT_W-1:0]     idx
    );
        field_result_t          r;
        logic [WORD_BITS-1:0]   mask;
        logic [2*WORD_BITS-1:0] pair;
        int unsigned            word;
        int unsigned            off;
        r = '0;
        mask = (fw >= WORD_BITS) ? '1 : ((64'd1 << fw) - 64'd1);
        if (fw == 0 || fw > WORD_BITS) begin
            r.error = 1'b1;
        end else if (op == OP_APPEND) begin
            if (model_count + fw > CAP_BITS) begin
                r.error = 1'b1;
            end else begin
                word = model_count / WORD_BITS;
                off  = model_count % WORD_BITS;
                pair = {{WORD_BITS{1'b0}}, fv & mask} << off;
                model_words[word] |= pair[WORD_BITS-1:0];
                if (word + 1 < DEPTH_WORDS) begin
                    model_words[word + 1] |= pair[2*WORD_BITS-1:WORD_BITS];
                end
                model_count += fw;
            end
        end else begin
            if (idx > model_count) begin
                r.error = 1'b1;
            end else begin
                word = idx / WORD_BITS;
                off  = idx % WORD_BITS;
                // Words past the end of the memory read as zero.
                pair = {(word + 1 < DEPTH_WORDS) ? model_words[word + 1] : {WORD_BITS{1'b0}},
                        (word < DEPTH_WORDS) ? model_words[word] : {WORD_BITS{1'b0}}} >> off;
                r.read_data = pair[WORD_BITS-1:0] & mask;
            end
        end
        r.bit_count = model_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch at result %0d: %s", $time, results_checked, msg);
        end
        mismatch_count++;
    endtask

    task automatic send_item(
        input logic                 op,
        input logic [WIDTH_W-1:0]   fw,
        input logic [WORD_BITS-1:0] fv,
        input logic [CNT_W-1:0]     idx
    );
        field_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, fv, fw};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_field_store(op, fw, fv, idx);
        field_expected = {field_expected, predicted};
        items_sent++;
        if (!no_idle && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic send_random_item(input int append_pct);
        logic                 op;
        logic [WIDTH_W-1:0]   fw;
        logic [WORD_BITS-1:0] fv;
        logic [CNT_W-1:0]     idx;
        int                   pick;
        int                   near;
        op = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_READ;
        pick = $urandom_range(99);
        if (pick < 5) begin
            fw = ($urandom_range(1) == 0) ? '0 : WIDTH_W'($urandom_range(127, 65));
        end else if (pick < 40) begin
            fw = 7'd64;
        end else begin
            fw = WIDTH_W'($urandom_range(64, 1));
        end
        fv = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5) begin
            fv = '1;
        end else if (pick < 8) begin
            fv = '0;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            idx = CNT_W'($urandom);
        end else if (pick < 25) begin
            // Indexes around the end, including one past it.
            near = int'(model_count) + 1 - int'($urandom_range(4));
            if (near < 0) near = 0;
            idx = CNT_W'(near);
        end else begin
            idx = CNT_W'($urandom_range(model_count, 0));
        end
        send_item(op, fw, fv, idx);
    endtask

    task automatic test_directed_fields();
        send_item(OP_READ, 7'd1, '0, 17'd0);
        send_item(OP_READ, 7'd1, '0, 17'd1);
        send_item(OP_APPEND, 7'd0, '1, 17'd0);
        send_item(OP_READ, 7'd0, '0, 17'd0);
        send_item(OP_APPEND, 7'd127, '1, 17'd0);
        send_item(OP_READ, 7'd65, '0, 17'd0);
        send_item(OP_APPEND, 7'd1, '1, '1);
        // Straddles the first word boundary.
        send_item(OP_APPEND, 7'd64, '1, 17'd0);
        send_item(OP_APPEND, 7'd63, 64'h5555_5555_5555_5555, 17'd0);
        send_item(OP_APPEND, 7'd64, 64'hDEAD_BEEF_0123_4567, 17'd0);
        // Only the low seven bits are stored, and they are all zero.
        send_item(OP_APPEND, 7'd7, 64'hFFFF_FFFF_FFFF_FF80, 17'd0);
        send_item(OP_READ, 7'd64, '0, 17'd0);
        send_item(OP_READ, 7'd64, '1, 17'd1);
        send_item(OP_READ, 7'd1, '0, 17'd64);
        send_item(OP_READ, 7'd64, '0, 17'd150);
        send_item(OP_READ, 7'd64, '0, CNT_W'(model_count));
        send_item(OP_READ, 7'd8, '0, CNT_W'(model_count + 1));
        send_item(OP_READ, 7'd64, '0, '1);
        send_item(OP_APPEND, 7'd64, 64'h8000_0000_0000_0001, 17'd0);
        send_item(OP_READ, 7'd64, '0, 17'd199);
        send_item(OP_READ, 7'd33, '0, 17'd127);
    endtask

    task automatic test_random_mix();
        repeat (100) send_random_item(60);
    endtask

    task automatic test_result_backpressure();
        // The receiver holds off while items keep coming, so the input stalls.
        hold_requests++;
        no_idle = 1'b1;
        repeat (40) send_random_item(60);
        no_idle = 1'b0;
    endtask

    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        repeat (50) send_random_item(55);
        no_idle = 1'b0;
    endtask

    task automatic test_fill_to_capacity();
        int room;
        int pick;
        while (model_count + WORD_BITS <= CAP_BITS) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_random_item(0);
            end else if (pick < 97) begin
                send_item(OP_APPEND, 7'd64, {$urandom, $urandom}, CNT_W'($urandom));
            end else begin
                send_item(OP_APPEND, WIDTH_W'($urandom_range(64, 1)), {$urandom, $urandom},
                          CNT_W'($urandom));
            end
        end
        room = CAP_BITS - int'(model_count);
        send_item(OP_APPEND, WIDTH_W'(room + 1), {$urandom, $urandom}, '0);
        if (room > 0) begin
            send_item(OP_APPEND, WIDTH_W'(room), '1, '0);
        end
        send_item(OP_APPEND, 7'd1, '1, '0);
        send_item(OP_APPEND, 7'd64, {$urandom, $urandom}, '0);
        // Reads at and near the very end of the memory.
        send_item(OP_READ, 7'd64, '0, CNT_W'(CAP_BITS));
        send_item(OP_READ, 7'd64, '0, CNT_W'(CAP_BITS - 1));
        send_item(OP_READ, 7'd64, '0, CNT_W'(CAP_BITS - 64));
        send_item(OP_READ, 7'd1, '0, CNT_W'(CAP_BITS + 1));
        send_item(OP_READ, 7'd64, '0, '1);
        repeat (20) send_random_item(30);
    endtask

    // Receiver: random stalls, a quiet mode, and a long counted hold-off on request.
    initial begin
        hold_served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge aclk) begin : result_checker
        field_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (field_expected.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                want = field_expected.pop_front();
                if (m_tdata[WORD_BITS-1:0] !== want.read_data) begin
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              m_tdata[WORD_BITS-1:0], want.read_data));
                end
                if (m_tuser[0] !== want.error) begin
                    report_mismatch($sformatf("error %b, expected %b", m_tuser[0], want.error));
                end
                if (m_tdata[WORD_BITS +: CNT_W] !== want.bit_count) begin
                    report_mismatch($sformatf("bit_count %0d, expected %0d",
                                              m_tdata[WORD_BITS +: CNT_W], want.bit_count));
                end
                results_checked++;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", field_expected.size());
        $display("packed_bit_field_store regression: fail");
        $finish;
    end

    initial begin
        int waited;
        foreach (model_words[i]) model_words[i] = '0;
        model_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        no_idle         = 1'b0;
        hold_requests   = 0;
        waited          = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_fields();
        test_random_mix();
        test_result_backpressure();
        test_no_idle_stretch();
        test_fill_to_capacity();
        s_tvalid <= 1'b0;

        while (field_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (field_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", field_expected.size()));
        end
        repeat (16) @(posedge aclk);

        $display("Sent %0d items: appends, reads, rejected widths, reads past the end,",
                 items_sent);
        $display("fill to capacity with overflow; %0d results checked, final bit count %0d.",
                 results_checked, model_count);
        if (mismatch_count == 0) begin
            $display("packed_bit_field_store regression: pass");
        end else begin
            $display("packed_bit_field_store regression: fail");
        end
        $finish;
    end

endmodule
